[design/gpac_pkg.sv]
package gpac_pkg;

    // Sample and register widths
    localparam int ACCEL_W = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 32;
    localparam int CFG_W   = 32;

    // Register reset values
    localparam logic [SQ_W-1:0]  MIN_MAG_SQ_RESET   = 32'd13586596;
    localparam logic [SQ_W-1:0]  MAX_MAG_SQ_RESET   = 32'd20304036;
    localparam logic [MAG_W-1:0] MIN_DOMINANT_RESET = 16'd3686;
    localparam logic [MAG_W-1:0] MAX_OTHER_RESET    = 16'd1024;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_MAG_SQ = 2'd0,
        CFG_MAX_MAG_SQ = 2'd1,
        CFG_MIN_DOM    = 2'd2,
        CFG_MAX_OTHER  = 2'd3
    } cfg_reg_t;

    // Sensor axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Pose codes; each pose also indexes its capture slot
    localparam logic [1:0] POSE_SCREEN_UP = 2'd0;
    localparam logic [1:0] POSE_TOP_UP    = 2'd1;
    localparam logic [1:0] POSE_RIGHT_UP  = 2'd2;
    localparam int         NUM_POSES      = 3;

    // Result word, accepted in the lowest bit
    typedef struct packed {
        logic [1:0] pad;
        logic       neg_z;
        logic       neg_y;
        logic       neg_x;
        logic [1:0] map_z;
        logic [1:0] map_y;
        logic [1:0] map_x;
        logic       remap_valid;
        logic       all_captured;
        logic [1:0] dominant_axis;
        logic       accepted;
    } result_t;

    // One capture slot
    typedef struct packed {
        logic       captured;
        logic       negative;
        logic [1:0] axis;
    } capture_t;

endpackage

[design/gravity_pose_axis_calibrator_top.sv]
// Gravity pose axis calibrator.
// Input stream (s_axis_*): one accelerometer sample per transaction, tagged in
// tuser with a clear flag and a pose (screen up, top up, right up). A sample
// passing the magnitude window, dominant-axis minimum and off-axis limit is
// stored as the axis/sign for its pose; clear empties all three captures.
// Output stream (m_axis_*): one result per input transaction, giving
// acceptance, the dominant axis and the screen X/Y/Z mapping after the update.
// Configuration channel (cfg_*): register writes, always ready; write only
// while the block is idle.
// A sample passes through the input register, the squares register and the result
// register before its result is valid. Throughput: one sample per cycle while
// the receiver does not stall; the three 16x16 squares are computed in parallel
// in one stage.
// When the receiver stalls, the result register holds and the two earlier
// stages still fill, so up to two more samples are taken before tready drops.
// Reset clears all captures, all stage valids and restores register defaults.
module gravity_pose_axis_calibrator_top
    import gpac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic [2:0]  s_axis_tuser,   // clear[0], pose[2:1]
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // accepted[0], dominant_axis[2:1], all_captured[3],
                                        // remap_valid[4], map_x[6:5], map_y[8:7],
                                        // map_z[10:9], neg_x[11], neg_y[12], neg_z[13], zero pad
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers
    logic [SQ_W-1:0]  min_mag_sq_reg;
    logic [SQ_W-1:0]  max_mag_sq_reg;
    logic [MAG_W-1:0] min_dom_reg;
    logic [MAG_W-1:0] max_other_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mag_sq_reg <= MIN_MAG_SQ_RESET;
            max_mag_sq_reg <= MAX_MAG_SQ_RESET;
            min_dom_reg    <= MIN_DOMINANT_RESET;
            max_other_reg  <= MAX_OTHER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MIN_MAG_SQ: min_mag_sq_reg <= cfg_data;
                CFG_MAX_MAG_SQ: max_mag_sq_reg <= cfg_data;
                CFG_MIN_DOM:    min_dom_reg    <= cfg_data[MAG_W-1:0];
                CFG_MAX_OTHER:  max_other_reg  <= cfg_data[MAG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline flow control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv2;
    logic adv3;
    logic s_accept;

    assign adv3          = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign adv2          = s1_valid_reg && (!s2_valid_reg || adv3);
    assign s_axis_tready = !s1_valid_reg || adv2;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
                s1_valid_reg <= 1'b1;
            else if (adv2)
                s1_valid_reg <= 1'b0;

            if (adv2)
                s2_valid_reg <= 1'b1;
            else if (adv3)
                s2_valid_reg <= 1'b0;

            if (adv3)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage 1: input register
    logic                     s1_clear_reg;
    logic [1:0]               s1_pose_reg;
    logic signed [ACCEL_W-1:0] s1_accel_reg [NUM_POSES];

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_clear_reg    <= s_axis_tuser[0];
            s1_pose_reg     <= s_axis_tuser[2:1];
            s1_accel_reg[0] <= s_axis_tdata[15:0];
            s1_accel_reg[1] <= s_axis_tdata[31:16];
            s1_accel_reg[2] <= s_axis_tdata[47:32];
        end
    end

    // Stage 2: magnitudes, signs and sum of squares
    logic [MAG_W-1:0] mag_next [NUM_POSES];
    logic [SQ_W-1:0]  sq_next  [NUM_POSES];
    logic [SQ_W-1:0]  sum_sq_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = s1_accel_reg[i][ACCEL_W-1] ?
                          (~s1_accel_reg[i] + 16'd1) : s1_accel_reg[i];
            sq_next[i]  = mag_next[i] * mag_next[i];
        end
        sum_sq_next = sq_next[0] + sq_next[1] + sq_next[2];
    end

    logic             s2_clear_reg;
    logic [1:0]       s2_pose_reg;
    logic [MAG_W-1:0] s2_mag_reg [NUM_POSES];
    logic [2:0]       s2_neg_reg;
    logic [SQ_W-1:0]  s2_sum_sq_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_clear_reg  <= s1_clear_reg;
            s2_pose_reg   <= s1_pose_reg;
            s2_mag_reg    <= mag_next;
            s2_neg_reg    <= {s1_accel_reg[2][ACCEL_W-1], s1_accel_reg[1][ACCEL_W-1],
                              s1_accel_reg[0][ACCEL_W-1]};
            s2_sum_sq_reg <= sum_sq_next;
        end
    end

    // Stage 3: tests, dominant axis selection and capture update
    logic [1:0] best;
    logic       pass;
    logic [1:0] dom;
    logic       accept;
    capture_t   cap_reg  [NUM_POSES];
    capture_t   cap_next [NUM_POSES];
    result_t    res_next;
    result_t    res_reg;

    always_comb
    begin
        // First axis wins ties
        best = AXIS_X;
        if (s2_mag_reg[1] > s2_mag_reg[0])
            best = AXIS_Y;
        if (s2_mag_reg[2] > s2_mag_reg[best])
            best = AXIS_Z;

        pass = (s2_sum_sq_reg >= min_mag_sq_reg) && (s2_sum_sq_reg <= max_mag_sq_reg)
               && (s2_mag_reg[best] >= min_dom_reg);
        for (int i = 0; i < 3; i++)
        begin
            if ((2'(i) != best) && (s2_mag_reg[i] > max_other_reg))
                pass = 1'b0;
        end

        accept = !s2_clear_reg && (s2_pose_reg != AXIS_NONE) && pass;
        dom    = accept ? best : AXIS_NONE;

        // Capture slots after this sample
        for (int i = 0; i < 3; i++)
        begin
            if (s2_clear_reg)
                cap_next[i] = '{captured: 1'b0, negative: 1'b0, axis: AXIS_NONE};
            else if (accept && (s2_pose_reg == 2'(i)))
                cap_next[i] = '{captured: 1'b1, negative: s2_neg_reg[best], axis: best};
            else
                cap_next[i] = cap_reg[i];
        end

        // Result from the updated captures
        res_next               = '0;
        res_next.accepted      = accept;
        res_next.dominant_axis = dom;
        res_next.all_captured  = cap_next[0].captured && cap_next[1].captured
                                 && cap_next[2].captured;
        res_next.remap_valid   = res_next.all_captured
                                 && (cap_next[0].axis != cap_next[1].axis)
                                 && (cap_next[0].axis != cap_next[2].axis)
                                 && (cap_next[1].axis != cap_next[2].axis);
        res_next.map_x = cap_next[POSE_RIGHT_UP].captured  ? cap_next[POSE_RIGHT_UP].axis
                                                           : AXIS_NONE;
        res_next.map_y = cap_next[POSE_TOP_UP].captured    ? cap_next[POSE_TOP_UP].axis
                                                           : AXIS_NONE;
        res_next.map_z = cap_next[POSE_SCREEN_UP].captured ? cap_next[POSE_SCREEN_UP].axis
                                                           : AXIS_NONE;
        res_next.neg_x = cap_next[POSE_RIGHT_UP].captured  && cap_next[POSE_RIGHT_UP].negative;
        res_next.neg_y = cap_next[POSE_TOP_UP].captured    && cap_next[POSE_TOP_UP].negative;
        res_next.neg_z = cap_next[POSE_SCREEN_UP].captured && cap_next[POSE_SCREEN_UP].negative;
    end

    // Capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                cap_reg[i] <= '{captured: 1'b0, negative: 1'b0, axis: AXIS_NONE};
        end
        else if (adv3)
        begin
            cap_reg <= cap_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (adv3)
            res_reg <= res_next;
    end

    assign m_axis_tdata = res_reg;

endmodule
